// ===== rtl/servo_channel_output_limit_macros.svh =====
// Assertion helpers shared by the servo output limiter.
`ifndef SERVO_CHANNEL_OUTPUT_LIMIT_MACROS_SVH
`define SERVO_CHANNEL_OUTPUT_LIMIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SCOL_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SCOL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scol_pkg.sv =====
package scol_pkg;

    // APB register map
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_CENTER_OFFSET = 3'd0,
        REG_UPPER_LIMIT   = 3'd1,
        REG_LOWER_LIMIT   = 3'd2,
        REG_REVERSE       = 3'd3,
        REG_SAFETY_EN     = 3'd4,
        REG_SAFETY_VALUE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [10:0] center_offset;
        logic signed [7:0]  upper_limit;
        logic signed [7:0]  lower_limit;
        logic               reverse_output;
        logic               safety_enable;
        logic signed [7:0]  safety_value;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_offset:  11'sd0,
        upper_limit:    8'sd100,
        lower_limit:    -8'sd100,
        reverse_output: 1'b0,
        safety_enable:  1'b0,
        safety_value:   8'sd0
    };

    // input reg, product stage, reciprocal stage, output reg
    localparam int NUM_STAGES = 4;

    // x / 100 for x < 2^25: (x * ceil(2^32 / 100)) >> 32
    localparam logic [25:0] RAW_RECIP = 26'd42949673;
    localparam int          RAW_SHIFT = 32;

    // x / 100000 = (x >> 5) / 3125; (y * ceil(2^43 / 3125)) >> 43 for y < 2^31
    localparam int          SCALE_PRESHIFT = 5;
    localparam logic [31:0] SCALE_RECIP    = 32'd2814749768;
    localparam int          SCALE_SHIFT    = 43;

    // tenths of a percent to servo units: x + x/32 - x/128 + x/512, floor shifts
    function automatic logic signed [11:0] tenths_to_units(input logic signed [11:0] x);
        logic signed [12:0] y;
        logic signed [12:0] acc;
        y   = 13'(x >>> 5);
        acc = 13'(x) + y;
        y   = y >>> 2;
        acc = acc - y;
        y   = y >>> 2;
        acc = acc + y;
        return acc[11:0];
    endfunction

    // percent to servo units: floor(41*x/4) - trunc(x/64)
    function automatic logic signed [11:0] pct_to_units(input logic signed [7:0] x);
        logic signed [13:0] t;
        logic signed [11:0] q;
        t = 14'(x) * 14'sd41;
        q = 12'(x >>> 6);
        if (x[7] && (x[5:0] != 6'd0)) begin
            q = q + 12'sd1;
        end
        return 12'(t >>> 2) - q;
    endfunction

endpackage

// ===== rtl/scol_cfg.sv =====
module scol_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scol_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output scol_pkg::cfg_t              cfg
);
    import scol_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_CENTER_OFFSET: cfg_next.center_offset  = pwdata[10:0];
                REG_UPPER_LIMIT:   cfg_next.upper_limit    = pwdata[7:0];
                REG_LOWER_LIMIT:   cfg_next.lower_limit    = pwdata[7:0];
                REG_REVERSE:       cfg_next.reverse_output = pwdata[0];
                REG_SAFETY_EN:     cfg_next.safety_enable  = pwdata[0];
                REG_SAFETY_VALUE:  cfg_next.safety_value   = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_OFFSET: prdata = {21'd0, cfg_reg.center_offset};
            REG_UPPER_LIMIT:   prdata = {24'd0, cfg_reg.upper_limit};
            REG_LOWER_LIMIT:   prdata = {24'd0, cfg_reg.lower_limit};
            REG_REVERSE:       prdata = {31'd0, cfg_reg.reverse_output};
            REG_SAFETY_EN:     prdata = {31'd0, cfg_reg.safety_enable};
            REG_SAFETY_VALUE:  prdata = {24'd0, cfg_reg.safety_value};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/scol_pipe.sv =====
module scol_pipe (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scol_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,
    output logic [scol_pkg::NUM_STAGES-1:0] occ
);
    import scol_pkg::*;

    // stage valids and load enables
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign occ      = vld_reg;

    // stage 0: input register
    logic signed [24:0] mix0_reg;
    logic               act0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mix0_reg <= s_tdata[24:0];
            act0_reg <= s_tuser;
        end
    end

    // stage 1: offset clamp, |sum| * |span|, |sum| * 1/100
    logic signed [11:0] lp;
    logic signed [11:0] ln;
    logic signed [11:0] ofs;
    logic signed [12:0] span;
    logic [24:0]        aq;
    logic [11:0]        aspan;
    logic [36:0]        prod1;
    logic [50:0]        rawp;

    logic [30:0]        m1_next;
    logic [30:0]        m1_reg;
    logic               neg1_reg;
    logic signed [11:0] ou1_reg;
    logic [18:0]        rmag1_reg;
    logic               rneg1_reg;
    logic               act1_reg;

    always_comb begin
        lp  = $signed(cfg.upper_limit) * 12'sd10;
        ln  = $signed(cfg.lower_limit) * 12'sd10;
        ofs = 12'($signed(cfg.center_offset));
        if (ofs > lp) begin
            ofs = lp;
        end
        if (ofs < ln) begin
            ofs = ln;
        end
        // positive sum scales toward the upper span, negative toward the lower
        span  = (mix0_reg > 0) ? (13'(lp) - 13'(ofs)) : (13'(ln) - 13'(ofs));
        aq    = mix0_reg[24] ? 25'(-mix0_reg) : 25'(mix0_reg);
        aspan = span[12] ? 12'(-span) : 12'(span);
        prod1 = 37'(aq) * 37'(aspan);
        rawp  = 51'(aq) * 51'(RAW_RECIP);
        m1_next = prod1[SCALE_PRESHIFT+30:SCALE_PRESHIFT];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            m1_reg    <= m1_next;
            neg1_reg  <= span[12];
            ou1_reg   <= tenths_to_units(ofs);
            rmag1_reg <= rawp[RAW_SHIFT+18:RAW_SHIFT];
            rneg1_reg <= mix0_reg[24];
            act1_reg  <= act0_reg;
        end
    end

    // stage 2: divide by 3125 through the reciprocal
    logic [62:0]        p2_reg;
    logic               neg2_reg;
    logic signed [11:0] ou2_reg;
    logic [18:0]        raw2_reg;
    logic               act2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p2_reg   <= 63'(m1_reg) * 63'(SCALE_RECIP);
            neg2_reg <= neg1_reg;
            ou2_reg  <= ou1_reg;
            raw2_reg <= rneg1_reg ? 19'(-rmag1_reg) : rmag1_reg;
            act2_reg <= act1_reg;
        end
    end

    // stage 3: add offset, clamp, reverse, safety override
    logic [19:0]        smag;
    logic signed [20:0] scaled;
    logic signed [20:0] acc;
    logic signed [20:0] clp;
    logic signed [20:0] cln;
    logic signed [11:0] servo;
    logic [31:0]        out_next;
    logic [31:0]        out_reg;

    always_comb begin
        smag   = p2_reg[SCALE_SHIFT+19:SCALE_SHIFT];
        scaled = neg2_reg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        acc    = scaled + 21'(ou2_reg);
        clp    = 21'(tenths_to_units(lp));
        cln    = 21'(tenths_to_units(ln));
        if (acc > clp) begin
            acc = clp;
        end
        if (acc < cln) begin
            acc = cln;
        end
        servo = acc[11:0];
        if (cfg.reverse_output) begin
            servo = -servo;
        end
        if (cfg.safety_enable && act2_reg) begin
            servo = pct_to_units(cfg.safety_value);
        end
        out_next = {1'b0, raw2_reg, servo};
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

// ===== rtl/servo_channel_output_limit.sv =====
// Throughput: one transaction per cycle; four register stages (input, product,
//   reciprocal multiply, output), each moving whenever the stage after it frees up.
// Reset: synchronous, active-low aresetn clears all stage valids and loads the
//   register defaults (offset 0, limits +100/-100, no reverse, no safety).
`include "servo_channel_output_limit_macros.svh"

module servo_channel_output_limit (
    input  logic                        aclk,
    input  logic                        aresetn,

    // APB register port, pready tied high
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scol_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [24:0] mix_sum (signed), [31:25] zero
    input  logic                        s_tuser,   // [0] safety_active

    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata    // [11:0] servo_value, [30:12] raw_value,
                                                   // [31] zero
);
    import scol_pkg::*;

    cfg_t                  cfg;
    logic [NUM_STAGES-1:0] occ;
    logic                  in_xfer;
    logic                  out_xfer;

    // The user must change registers only between traffic (not enforced here);
    // the datapath reads them directly rather than carrying a copy down the pipe.
    scol_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Datapath: stage 1 clamps the sub-trim and forms |sum| * |span| >> 5 plus
    // the /100 reciprocal product; stage 2 continues /100000 (after the >>5) with a
    // reciprocal multiply by 1/3125; the output stage adds the converted
    // offset, clamps to the endpoints, reverses and applies the safety preset.
    scol_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .occ      (occ)
    );

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Input may only stall when every stage holds a transaction.
    `SCOL_ASSERT_IMPLIES(a_stall_only_when_full, aclk, aresetn, !s_tready, &occ, "input stalled with a free stage")
    // Transactions in flight change only by accepted inputs and delivered results.
    `SCOL_ASSERT_NEXT(a_occupancy, aclk, aresetn, 1'b1, $countones(occ) == $past($countones(occ)) + $past(32'(in_xfer)) - $past(32'(out_xfer)), "transaction lost or duplicated in pipe")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic [11:0] servo_value;
    logic [18:0] raw_value;
} servo_result_t;

class servo_result_checker;
    localparam longint SCALE_DIV = 100000;
    localparam longint RAW_DIV = 100;

    scol_pkg::cfg_t cfg;
    servo_result_t pending_results[$];
    int errors;

    function new();
        cfg = scol_pkg::CFG_RESET;
        errors = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
        case (idx)
            scol_pkg::REG_CENTER_OFFSET: cfg.center_offset = value[10:0];
            scol_pkg::REG_UPPER_LIMIT:   cfg.upper_limit = value[7:0];
            scol_pkg::REG_LOWER_LIMIT:   cfg.lower_limit = value[7:0];
            scol_pkg::REG_REVERSE:       cfg.reverse_output = value[0];
            scol_pkg::REG_SAFETY_EN:     cfg.safety_enable = value[0];
            scol_pkg::REG_SAFETY_VALUE:  cfg.safety_value = value[7:0];
            default: ;
        endcase
    endfunction

    // x + x/32 - x/128 + x/512, each step a floor shift of the last partial
    function longint tenths_units(longint x);
        longint y;
        y = x >>> 5;
        x = x + y;
        y = y >>> 2;
        x = x - y;
        return x + (y >>> 2);
    endfunction

    function servo_result_t limited_output(longint sum, bit active);
        servo_result_t r;
        longint q, raw, ofs, lp, ln, clp, cln, pct;
        q = sum;
        raw = sum / RAW_DIV;
        ofs = longint'($signed(cfg.center_offset));
        lp = 10 * longint'($signed(cfg.upper_limit));
        ln = 10 * longint'($signed(cfg.lower_limit));
        // lower clamp last, so it wins when the limits are crossed
        if (ofs > lp) ofs = lp;
        if (ofs < ln) ofs = ln;
        if (q > 0)
            q = q * (lp - ofs) / SCALE_DIV;
        else if (q < 0)
            q = (-q) * (ln - ofs) / SCALE_DIV;
        q = q + tenths_units(ofs);
        clp = tenths_units(lp);
        cln = tenths_units(ln);
        if (q > clp) q = clp;
        if (q < cln) q = cln;
        if (cfg.reverse_output) q = -q;
        if (cfg.safety_enable && active) begin
            pct = longint'($signed(cfg.safety_value));
            q = ((pct * 41) >>> 2) - pct / 64;
        end
        r.servo_value = q[11:0];
        r.raw_value = raw[18:0];
        return r;
    endfunction

    function void note_input(longint sum, bit active);
        pending_results.push_back(limited_output(sum, active));
    endfunction

    function void check_result(logic [31:0] tdata);
        servo_result_t exp_r;
        if (pending_results.size() == 0) begin
            $error("unexpected result transaction, tdata %h", tdata);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (tdata[11:0] !== exp_r.servo_value) begin
            $error("servo_value: expected %0d, actual %0d",
                   $signed(exp_r.servo_value), $signed(tdata[11:0]));
            errors++;
        end
        if (tdata[30:12] !== exp_r.raw_value) begin
            $error("raw_value: expected %0d, actual %0d",
                   $signed(exp_r.raw_value), $signed(tdata[30:12]));
            errors++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module tb;
    // run guard, well above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_REGS = 6;
    localparam int RAND_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 84;
    // drain margin after the last result: pipeline depth plus slack
    localparam int DRAIN_CYCLES = scol_pkg::NUM_STAGES + 2;

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [scol_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [31:0]                 s_tdata;   // [24:0] mix_sum (signed), [31:25] zero
    logic                        s_tuser;   // [0] safety_active
    logic                        m_tvalid;
    logic                        m_tready;
    logic [31:0]                 m_tdata;   // [11:0] servo_value, [30:12] raw_value, [31] zero

    servo_result_checker sb = new();

    // burst flags: when set, that side never idles for the current phase
    bit src_burst;
    bit snk_burst;
    int cycles;

    servo_channel_output_limit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Global watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitors sample pre-edge values, i.e. exactly what the DUT saw.
    // Prediction uses the config copy at acceptance; config only changes
    // while the pipeline is empty, so this matches the DUT.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input($signed(s_tdata[24:0]), s_tuser);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Result sink: per transaction, optionally stall with tready low (never in burst
    // phases), then hold tready until a transaction completes.
    initial begin
        int stall;
        forever begin
            stall = snk_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // APB write: setup phase, access phase until pready, then back to idle.
    task automatic apb_write(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= scol_pkg::ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] ofs, input logic [31:0] upper,
                                 input logic [31:0] lower, input logic [31:0] rev,
                                 input logic [31:0] safe_en, input logic [31:0] safe_val);
        apb_write(scol_pkg::REG_CENTER_OFFSET, ofs);
        apb_write(scol_pkg::REG_UPPER_LIMIT, upper);
        apb_write(scol_pkg::REG_LOWER_LIMIT, lower);
        apb_write(scol_pkg::REG_REVERSE, rev);
        apb_write(scol_pkg::REG_SAFETY_EN, safe_en);
        apb_write(scol_pkg::REG_SAFETY_VALUE, safe_val);
    endtask

    // One input transaction; tvalid stays high across back-to-back items.
    task automatic send_sample(input longint sum, input bit active);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, sum[24:0]};
        s_tuser <= active;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let every expected result come out, then wait out the drain margin.
    // The first edge lets the monitor log the last accepted input.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mix of full-range bit patterns, the useful +/-150000 band, tiny
    // values around zero and the corner values.
    function automatic longint draw_sum();
        longint corners[8] = '{-16777216, 16777215, 0, 1, -1, 100000, -100000, 99};
        case ($urandom_range(0, 5))
            0, 1:    return longint'($signed(25'($urandom())));
            2, 3:    return longint'($urandom_range(0, 300000)) - 150000;
            4:       return longint'($urandom_range(0, 400)) - 200;
            default: return corners[$urandom_range(0, 7)];
        endcase
    endfunction

    // Register value: in range most of the time, else a raw 32-bit pattern.
    function automatic logic [31:0] draw_reg(input int lo, input int hi);
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($urandom_range(0, hi - lo) + lo);
    endfunction

    initial begin
        longint dir_sums[18] = '{0, 0, 1, -1, 99, -99, 100, -100, 100000, -100000,
                                 16777215, -16777216, 16777215, -16777216, 50000, -1,
                                 150000, -150000};
        bit dir_active[18] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 1, 1, 1, 1, 0, 0};
        // all inputs known from time zero
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset settings: field extremes, rounding around the
        // divisors, and safety_active ignored while no switch is assigned.
        foreach (dir_sums[i])
            send_sample(dir_sums[i], dir_active[i]);
        drain();

        for (int ph = 1; ph <= RAND_PHASES; ph++) begin
            case (ph)
                // max offset against max endpoints, safety at +125%
                1: load_settings(32'd1000, 32'd125, -32'sd125, 32'd0, 32'd1, 32'd125);
                // min offset, reversed, safety at -125%
                2: load_settings(-32'sd1000, 32'd125, -32'sd125, 32'd1, 32'd1, -32'sd125);
                // crossed limits: lower above upper, lower clamps win
                3: load_settings(32'($urandom_range(0, 2000)) - 32'd1000, -32'sd50,
                                 32'd60, 32'($urandom_range(0, 1)), 32'd0, 32'd0);
                // register bit-pattern extremes beyond the documented range
                4: load_settings(-32'sd1024, 32'd127, -32'sd128, 32'd1, 32'd1, -32'sd128);
                5: load_settings(32'd1023, -32'sd128, 32'd127, 32'd0, 32'd1, 32'd127);
                default: begin
                    load_settings(draw_reg(-1000, 1000), draw_reg(-125, 125),
                                  draw_reg(-125, 125), draw_reg(0, 1),
                                  draw_reg(0, 1), draw_reg(-125, 125));
                    // writes past the register map must not disturb anything
                    if (ph == RAND_PHASES - 1) begin
                        apb_write(NUM_REGS, $urandom());
                        apb_write(NUM_REGS + 1, $urandom());
                    end
                end
            endcase
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(draw_sum(), $urandom_range(0, 1));
            drain();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
